### hdl/sha1_pkg.sv
// Shared types, constants and helpers for the SHA-1 hash engine.
// No dependencies; used by sha1_hash_engine and sha1_round.
package sha1_pkg;

    typedef logic [31:0] t_word;

    typedef struct packed {
        t_word a;
        t_word b;
        t_word c;
        t_word d;
        t_word e;
    } t_vars;

    localparam int NUM_DIGEST = 5;
    localparam int BLK_WORDS  = 16;
    localparam int BLK_AW     = 4;
    localparam int ROUNDS     = 80;

    localparam t_word H_INIT [NUM_DIGEST] = '{
        32'h67452301, 32'hEFCDAB89, 32'h98BADCFE, 32'h10325476, 32'hC3D2E1F0
    };

    localparam t_word K_R0 = 32'h5A827999;
    localparam t_word K_R1 = 32'h6ED9EBA1;
    localparam t_word K_R2 = 32'h8F1BBCDC;
    localparam t_word K_R3 = 32'hCA62C1D6;

    localparam logic [7:0] PAD_BYTE = 8'h80;
    localparam logic [5:0] LEN_POS  = 6'd56;
    localparam logic [5:0] LAST_POS = 6'd63;
    localparam logic [6:0] LAST_RND = 7'(ROUNDS - 1);
    localparam logic [6:0] SCHED_RND = 7'(BLK_WORDS);

    function automatic t_word rotl(input t_word x, input int n);
        rotl = (x << n) | (x >> (32 - n));
    endfunction

endpackage

### hdl/sha1_hash_engine.sv
// SHA-1 hash engine top level: byte intake, padding and round sequencer.
// Depends on sha1_pkg, sha1_ram and sha1_round.
//
// Input channel (i_in_valid / o_in_stall): one beat per message byte.
// i_carries_byte marks a real byte; i_end_of_message closes the message after
// that byte, and may come alone so an empty message works.
// Output channel (o_out_valid / i_out_stall): five beats h0..h4 per message,
// o_final_word set on h4.
// Every 64th byte starts a compression: the 16-word block RAM holds the
// block and then the rolling schedule, and each round needs three reads from
// its two read ports, so a round is split over states ST_P1 and ST_P2; a
// block runs setup, 80 rounds and the chaining add, input stalled meanwhile.
// After the closing beat pad bytes go in at one per cycle outside compressions
// (up to 72, with a second compression), then the digest moves to an output buffer.
// The five result beats appear back to back; a stalled output holds its beat.
// New message bytes are taken while the digest drains; a closing beat waits
// until the buffer is empty.
// Reset (synchronous, active low) loads the initial chaining words and clears
// the length and fill counts; block RAM contents need no reset.
module sha1_hash_engine (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [7:0]  i_data_byte,
    input  logic        i_carries_byte,
    input  logic        i_end_of_message,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [31:0] o_digest_word,
    output logic [2:0]  o_word_number,
    output logic        o_final_word
);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_PAD  = 3'd1;
    localparam logic [2:0] ST_R0   = 3'd2;
    localparam logic [2:0] ST_P1   = 3'd3;
    localparam logic [2:0] ST_P2   = 3'd4;
    localparam logic [2:0] ST_ADD  = 3'd5;

    localparam logic [1:0] RET_IDLE = 2'd0;
    localparam logic [1:0] RET_PAD  = 2'd1;
    localparam logic [1:0] RET_FIN  = 2'd2;

    logic [2:0]             r_state, n_state;
    logic [1:0]             r_ret, n_ret;
    logic [5:0]             r_fill, n_fill;
    logic [60:0]            r_cnt, n_cnt;
    logic [63:0]            r_len, n_len;
    logic [23:0]            r_asm, n_asm;
    logic                   r_first, n_first;
    logic                   r_lenph, n_lenph;
    logic [6:0]             r_t, n_t;
    sha1_pkg::t_word        r_x, n_x;
    sha1_pkg::t_word        r_s1, n_s1;
    sha1_pkg::t_word        r_s2, n_s2;
    sha1_pkg::t_word        r_s3, n_s3;
    sha1_pkg::t_vars        r_v, n_v;
    sha1_pkg::t_word        r_h [sha1_pkg::NUM_DIGEST];
    sha1_pkg::t_word        n_h [sha1_pkg::NUM_DIGEST];
    sha1_pkg::t_word        r_obuf [sha1_pkg::NUM_DIGEST];
    sha1_pkg::t_word        n_obuf [sha1_pkg::NUM_DIGEST];
    logic [2:0]             r_onum, n_onum;
    logic                   r_obusy, n_obusy;

    logic                          ram_we;
    logic [sha1_pkg::BLK_AW-1:0]   ram_waddr;
    sha1_pkg::t_word               ram_wdata;
    logic [sha1_pkg::BLK_AW-1:0]   ram_ra0;
    logic [sha1_pkg::BLK_AW-1:0]   ram_ra1;
    sha1_pkg::t_word               ram_rd0;
    sha1_pkg::t_word               ram_rd1;

    sha1_pkg::t_word  rnd_w;
    sha1_pkg::t_vars  rnd_vars;
    sha1_pkg::t_word  vsum [sha1_pkg::NUM_DIGEST];
    sha1_pkg::t_word  vals [sha1_pkg::NUM_DIGEST];

    logic        in_acc;
    logic        out_acc;
    logic        put_en;
    logic [7:0]  put_byte;
    logic        lenph_now;
    logic [7:0]  len_byte;
    logic [60:0] cnt_after;

    sha1_ram #(
        .WIDTH(32),
        .DEPTH(sha1_pkg::BLK_WORDS)
    ) u_blk_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr0(ram_ra0),
        .i_raddr1(ram_ra1),
        .o_rdata0(ram_rd0),
        .o_rdata1(ram_rd1)
    );

    sha1_round u_round (
        .i_t   (r_t),
        .i_vars(r_v),
        .i_x   (r_x),
        .i_w8  (ram_rd0),
        .i_w3  (r_s3),
        .o_w   (rnd_w),
        .o_vars(rnd_vars)
    );

    assign o_in_stall    = (r_state != ST_IDLE) || (r_obusy && i_end_of_message);
    assign in_acc        = i_in_valid && !o_in_stall;
    assign o_out_valid   = r_obusy;
    assign out_acc       = r_obusy && !i_out_stall;
    assign o_digest_word = r_obuf[0];
    assign o_word_number = r_onum;
    assign o_final_word  = (r_onum == 3'(sha1_pkg::NUM_DIGEST - 1));

    assign lenph_now = r_lenph || (!r_first && (r_fill == sha1_pkg::LEN_POS));
    assign len_byte  = 8'(r_len >> {~r_fill[2:0], 3'b000});
    assign cnt_after = i_carries_byte ? r_cnt + 61'd1 : r_cnt;

    assign vals[0] = r_v.a;
    assign vals[1] = r_v.b;
    assign vals[2] = r_v.c;
    assign vals[3] = r_v.d;
    assign vals[4] = r_v.e;

    always_comb begin
        for (int i = 0; i < sha1_pkg::NUM_DIGEST; i++) begin
            vsum[i] = r_h[i] + vals[i];
        end
    end

    always_comb begin
        n_state  = r_state;
        n_ret    = r_ret;
        n_fill   = r_fill;
        n_cnt    = r_cnt;
        n_len    = r_len;
        n_asm    = r_asm;
        n_first  = r_first;
        n_lenph  = r_lenph;
        n_t      = r_t;
        n_x      = r_x;
        n_s1     = r_s1;
        n_s2     = r_s2;
        n_s3     = r_s3;
        n_v      = r_v;
        n_h      = r_h;
        n_obuf   = r_obuf;
        n_onum   = r_onum;
        n_obusy  = r_obusy;
        put_en   = 1'b0;
        put_byte = '0;
        ram_we   = 1'b0;
        ram_waddr = '0;
        ram_wdata = '0;
        ram_ra0  = '0;
        ram_ra1  = '0;

        case (r_state)
            ST_IDLE: begin
                if (in_acc) begin
                    put_en   = i_carries_byte;
                    put_byte = i_data_byte;
                    n_cnt    = cnt_after;
                    if (i_end_of_message) begin
                        n_len   = {cnt_after, 3'b000};
                        n_first = 1'b1;
                        n_lenph = 1'b0;
                    end
                    if (i_carries_byte && (r_fill == sha1_pkg::LAST_POS)) begin
                        n_state = ST_R0;
                        n_ret   = i_end_of_message ? RET_PAD : RET_IDLE;
                    end else if (i_end_of_message) begin
                        n_state = ST_PAD;
                    end
                end
            end
            ST_PAD: begin
                put_en = 1'b1;
                if (r_first) begin
                    put_byte = sha1_pkg::PAD_BYTE;
                end else if (lenph_now) begin
                    put_byte = len_byte;
                end else begin
                    put_byte = '0;
                end
                n_first = 1'b0;
                n_lenph = lenph_now;
                if (r_fill == sha1_pkg::LAST_POS) begin
                    n_state = ST_R0;
                    n_ret   = lenph_now ? RET_FIN : RET_PAD;
                end
            end
            ST_R0: begin
                n_v.a   = r_h[0];
                n_v.b   = r_h[1];
                n_v.c   = r_h[2];
                n_v.d   = r_h[3];
                n_v.e   = r_h[4];
                n_t     = '0;
                ram_ra0 = 4'd0;
                ram_ra1 = 4'd2;
                n_state = ST_P1;
            end
            ST_P1: begin
                n_x     = (r_t < sha1_pkg::SCHED_RND) ? ram_rd0 : (ram_rd0 ^ ram_rd1);
                ram_ra0 = r_t[3:0] + 4'd8;
                n_state = ST_P2;
            end
            ST_P2: begin
                if (r_t >= sha1_pkg::SCHED_RND) begin
                    ram_we    = 1'b1;
                    ram_waddr = r_t[3:0];
                    ram_wdata = rnd_w;
                end
                n_v  = rnd_vars;
                n_s1 = rnd_w;
                n_s2 = r_s1;
                n_s3 = r_s2;
                if (r_t == sha1_pkg::LAST_RND) begin
                    n_state = ST_ADD;
                end else begin
                    n_t     = r_t + 7'd1;
                    ram_ra0 = r_t[3:0] + 4'd1;
                    ram_ra1 = r_t[3:0] + 4'd3;
                    n_state = ST_P1;
                end
            end
            ST_ADD: begin
                case (r_ret)
                    RET_FIN: begin
                        n_obuf  = vsum;
                        n_onum  = '0;
                        n_obusy = 1'b1;
                        n_h     = sha1_pkg::H_INIT;
                        n_cnt   = '0;
                        n_state = ST_IDLE;
                    end
                    RET_PAD: begin
                        n_h     = vsum;
                        n_state = ST_PAD;
                    end
                    default: begin
                        n_h     = vsum;
                        n_state = ST_IDLE;
                    end
                endcase
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase

        if (put_en) begin
            n_asm  = {r_asm[15:0], put_byte};
            n_fill = r_fill + 6'd1;
            if (r_fill[1:0] == 2'd3) begin
                ram_we    = 1'b1;
                ram_waddr = r_fill[5:2];
                ram_wdata = {r_asm, put_byte};
            end
        end

        if (out_acc) begin
            for (int i = 0; i < sha1_pkg::NUM_DIGEST - 1; i++) begin
                n_obuf[i] = r_obuf[i + 1];
            end
            n_onum = r_onum + 3'd1;
            if (o_final_word) begin
                n_obusy = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_ret   <= RET_IDLE;
            r_fill  <= '0;
            r_cnt   <= '0;
            r_first <= 1'b0;
            r_lenph <= 1'b0;
            r_t     <= '0;
            r_h     <= sha1_pkg::H_INIT;
            r_onum  <= '0;
            r_obusy <= 1'b0;
        end else begin
            r_state <= n_state;
            r_ret   <= n_ret;
            r_fill  <= n_fill;
            r_cnt   <= n_cnt;
            r_first <= n_first;
            r_lenph <= n_lenph;
            r_t     <= n_t;
            r_h     <= n_h;
            r_onum  <= n_onum;
            r_obusy <= n_obusy;
        end
    end

    always_ff @(posedge i_clk) begin
        r_len  <= n_len;
        r_asm  <= n_asm;
        r_x    <= n_x;
        r_s1   <= n_s1;
        r_s2   <= n_s2;
        r_s3   <= n_s3;
        r_v    <= n_v;
        r_obuf <= n_obuf;
    end

endmodule

### hdl/sha1_ram.sv
// Generic synchronous RAM: one write port, two registered read ports.
// No dependencies.
module sha1_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr0,
    input  logic [$clog2(DEPTH)-1:0] i_raddr1,
    output logic [WIDTH-1:0]         o_rdata0,
    output logic [WIDTH-1:0]         o_rdata1
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata0 <= r_mem[i_raddr0];
        o_rdata1 <= r_mem[i_raddr1];
    end

endmodule

### hdl/sha1_round.sv
// One SHA-1 round: schedule word expansion and working-variable update.
// Depends on sha1_pkg.
module sha1_round (
    input  logic [6:0]           i_t,
    input  sha1_pkg::t_vars      i_vars,
    input  sha1_pkg::t_word      i_x,
    input  sha1_pkg::t_word      i_w8,
    input  sha1_pkg::t_word      i_w3,
    output sha1_pkg::t_word      o_w,
    output sha1_pkg::t_vars      o_vars
);

    sha1_pkg::t_word f;
    sha1_pkg::t_word k;
    sha1_pkg::t_word w;

    always_comb begin
        if (i_t < sha1_pkg::SCHED_RND) begin
            w = i_x;
        end else begin
            w = sha1_pkg::rotl(i_x ^ i_w8 ^ i_w3, 1);
        end

        if (i_t < 7'd20) begin
            f = (i_vars.b & i_vars.c) | (~i_vars.b & i_vars.d);
            k = sha1_pkg::K_R0;
        end else if (i_t < 7'd40) begin
            f = i_vars.b ^ i_vars.c ^ i_vars.d;
            k = sha1_pkg::K_R1;
        end else if (i_t < 7'd60) begin
            f = (i_vars.b & i_vars.c) | (i_vars.b & i_vars.d) | (i_vars.c & i_vars.d);
            k = sha1_pkg::K_R2;
        end else begin
            f = i_vars.b ^ i_vars.c ^ i_vars.d;
            k = sha1_pkg::K_R3;
        end

        o_w      = w;
        o_vars.a = sha1_pkg::rotl(i_vars.a, 5) + f + i_vars.e + k + w;
        o_vars.b = i_vars.a;
        o_vars.c = sha1_pkg::rotl(i_vars.b, 30);
        o_vars.d = i_vars.c;
        o_vars.e = i_vars.d;
    end

endmodule

### hdl/sha1_checker.sv
// Port-level checks on the digest output channel of the SHA-1 hash engine.
// Depends on nothing; bound to sha1_hash_engine below.
module sha1_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_out_valid,
    input logic        i_out_stall,
    input logic [31:0] o_digest_word,
    input logic [2:0]  o_word_number,
    input logic        o_final_word
);

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_digest_word)
            && $stable(o_word_number))
        else $error("stalled digest beat changed");

    a_final_on_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_final_word == (o_word_number == 3'd4)))
        else $error("final flag not on word four");

    a_word_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_word_number <= 3'd4))
        else $error("word number out of range");

    a_word_next: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_stall && !o_final_word |=> o_out_valid
            && (o_word_number == $past(o_word_number) + 3'd1))
        else $error("digest words not back to back in order");

endmodule

bind sha1_hash_engine sha1_checker u_sha1_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .o_out_valid  (o_out_valid),
    .i_out_stall  (i_out_stall),
    .o_digest_word(o_digest_word),
    .o_word_number(o_word_number),
    .o_final_word (o_final_word)
);
